@@ src/rtc_pkg.sv @@
package rtc_pkg;

    // Widths and defaults
    localparam int VAL_W           = 64;
    localparam int OUT_W           = 32;
    localparam int EPS_W           = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_FIELDS      = 15;
    localparam int REG_AW          = 6;
    localparam int RF_DEPTH        = 1 << REG_AW;
    localparam int PROG_LEN        = 116;
    localparam int PC_W            = 7;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [EPS_W-1:0] EPS_RESET   = 16'd1;
    localparam logic             REG_EPSILON = 1'b0;

    // Input item codes
    localparam logic       MODE_LOAD   = 1'b0;
    localparam logic       MODE_RAY    = 1'b1;
    localparam logic [1:0] VERTEX_NONE = 2'd3;

    // Miss reasons
    localparam logic [1:0] MISS_NONE     = 2'd0;
    localparam logic [1:0] MISS_PARALLEL = 2'd1;
    localparam logic [1:0] MISS_BEHIND   = 2'd2;
    localparam logic [1:0] MISS_OUTSIDE  = 2'd3;

    // Sequencer operations
    localparam logic [3:0] OP_LD     = 4'd0;
    localparam logic [3:0] OP_ADD    = 4'd1;
    localparam logic [3:0] OP_SUB    = 4'd2;
    localparam logic [3:0] OP_MUL    = 4'd3;
    localparam logic [3:0] OP_DIV    = 4'd4;
    localparam logic [3:0] OP_CHKPAR = 4'd5;
    localparam logic [3:0] OP_CHKBEH = 4'd6;
    localparam logic [3:0] OP_CHKOUT = 4'd7;
    localparam logic [3:0] OP_END    = 4'd8;

    // Register file map
    localparam int R_O   = 0;
    localparam int R_D   = 3;
    localparam int R_V0  = 6;
    localparam int R_E0  = 15;
    localparam int R_W   = 24;
    localparam int R_N   = 27;
    localparam int R_NDD = 30;
    localparam int R_T   = 31;
    localparam int R_S1  = 32;
    localparam int R_S2  = 33;
    localparam int R_P   = 34;
    localparam int R_Q   = 37;
    localparam int R_C   = 40;
    localparam int R_TMP = 43;

    typedef struct packed {
        logic [3:0]        op;
        logic [REG_AW-1:0] dst;
        logic [REG_AW-1:0] a;
        logic [REG_AW-1:0] b;
    } uop_t;

    typedef uop_t [PROG_LEN-1:0] prog_t;

    function automatic uop_t mk(logic [3:0] op, int d, int a, int b);
        uop_t u;
        u.op  = op;
        u.dst = REG_AW'(d);
        u.a   = REG_AW'(a);
        u.b   = REG_AW'(b);
        return u;
    endfunction

    function automatic logic [VAL_W-1:0] mag64(logic [VAL_W-1:0] a);
        return a[VAL_W-1] ? (VAL_W'(0) - a) : a;
    endfunction

    // Signed result from sign and 128-bit magnitude, saturated
    function automatic logic [VAL_W-1:0] from_mag(logic neg, logic [VAL_W-1:0] hi,
                                                 logic [VAL_W-1:0] lo);
        logic [VAL_W-1:0] limit;
        limit = neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        if (hi != '0 || lo > limit)
            return neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return neg ? (VAL_W'(0) - lo) : lo;
    endfunction

    function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
            return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return s[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] sat_sub(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
            return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return s[VAL_W-1:0];
    endfunction

    // Sequencer program for one ray
    function automatic prog_t build_prog();
        prog_t p;
        int    n;
        int    i1;
        int    i2;
        int    e;
        int    v;
        p = '0;
        n = 0;
        // copy ray and triangle into the register file
        for (int k = 0; k < NUM_FIELDS; k++) begin
            p[n] = mk(OP_LD, k, k, 0); n++;
        end
        // edges E0, E1, E2 and W = V2 - V0
        for (int c = 0; c < 3; c++) begin
            p[n] = mk(OP_SUB, R_E0 + c, R_V0 + 3 + c, R_V0 + c); n++;
        end
        for (int c = 0; c < 3; c++) begin
            p[n] = mk(OP_SUB, R_E0 + 3 + c, R_V0 + 6 + c, R_V0 + 3 + c); n++;
        end
        for (int c = 0; c < 3; c++) begin
            p[n] = mk(OP_SUB, R_E0 + 6 + c, R_V0 + c, R_V0 + 6 + c); n++;
        end
        for (int c = 0; c < 3; c++) begin
            p[n] = mk(OP_SUB, R_W + c, R_V0 + 6 + c, R_V0 + c); n++;
        end
        // normal N = E0 x W
        for (int c = 0; c < 3; c++) begin
            i1 = (c == 2) ? 0 : c + 1;
            i2 = (c == 0) ? 2 : c - 1;
            p[n] = mk(OP_MUL, R_N + c, R_E0 + i1, R_W + i2); n++;
            p[n] = mk(OP_MUL, R_TMP, R_E0 + i2, R_W + i1); n++;
            p[n] = mk(OP_SUB, R_N + c, R_N + c, R_TMP); n++;
        end
        // N.D and parallel test
        for (int c = 0; c < 3; c++) begin
            p[n] = mk(OP_MUL, (c == 0) ? R_NDD : R_TMP, R_N + c, R_D + c); n++;
            if (c > 0) begin
                p[n] = mk(OP_ADD, R_NDD, R_NDD, R_TMP); n++;
            end
        end
        p[n] = mk(OP_CHKPAR, 0, R_NDD, 0); n++;
        // numerator N.V0 - N.O
        for (int c = 0; c < 3; c++) begin
            p[n] = mk(OP_MUL, (c == 0) ? R_S1 : R_TMP, R_N + c, R_V0 + c); n++;
            if (c > 0) begin
                p[n] = mk(OP_ADD, R_S1, R_S1, R_TMP); n++;
            end
        end
        for (int c = 0; c < 3; c++) begin
            p[n] = mk(OP_MUL, (c == 0) ? R_S2 : R_TMP, R_N + c, R_O + c); n++;
            if (c > 0) begin
                p[n] = mk(OP_ADD, R_S2, R_S2, R_TMP); n++;
            end
        end
        p[n] = mk(OP_SUB, R_S1, R_S1, R_S2); n++;
        p[n] = mk(OP_DIV, R_T, R_S1, R_NDD); n++;
        p[n] = mk(OP_CHKBEH, 0, R_T, 0); n++;
        // hit point P = O + D*t
        for (int c = 0; c < 3; c++) begin
            p[n] = mk(OP_MUL, R_TMP, R_D + c, R_T); n++;
            p[n] = mk(OP_ADD, R_P + c, R_O + c, R_TMP); n++;
        end
        // inside-outside test per edge
        for (int k = 0; k < 3; k++) begin
            e = R_E0 + 3 * k;
            v = R_V0 + 3 * k;
            for (int c = 0; c < 3; c++) begin
                p[n] = mk(OP_SUB, R_Q + c, R_P + c, v + c); n++;
            end
            for (int c = 0; c < 3; c++) begin
                i1 = (c == 2) ? 0 : c + 1;
                i2 = (c == 0) ? 2 : c - 1;
                p[n] = mk(OP_MUL, R_C + c, e + i1, R_Q + i2); n++;
                p[n] = mk(OP_MUL, R_TMP, e + i2, R_Q + i1); n++;
                p[n] = mk(OP_SUB, R_C + c, R_C + c, R_TMP); n++;
            end
            for (int c = 0; c < 3; c++) begin
                p[n] = mk(OP_MUL, (c == 0) ? R_S1 : R_TMP, R_N + c, R_C + c); n++;
                if (c > 0) begin
                    p[n] = mk(OP_ADD, R_S1, R_S1, R_TMP); n++;
                end
            end
            p[n] = mk(OP_CHKOUT, 0, R_S1, 0); n++;
        end
        p[n] = mk(OP_END, 0, R_T, 0);
        return p;
    endfunction

endpackage

@@ src/rtc_front.sv @@
module rtc_front #(
    parameter int COORD_WIDTH = rtc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         push,
    output logic                                         full,
    input  logic                                         mode,
    input  logic [1:0]                                   vertex_index,
    input  logic signed [COORD_WIDTH-1:0]                point_x,
    input  logic signed [COORD_WIDTH-1:0]                point_y,
    input  logic signed [COORD_WIDTH-1:0]                point_z,
    input  logic signed [COORD_WIDTH-1:0]                dir_x,
    input  logic signed [COORD_WIDTH-1:0]                dir_y,
    input  logic signed [COORD_WIDTH-1:0]                dir_z,
    output logic                                         q_valid,
    input  logic                                         q_pop,
    output logic [rtc_pkg::NUM_FIELDS*COORD_WIDTH-1:0]   q_data
);

    localparam int ENT_W = rtc_pkg::NUM_FIELDS * COORD_WIDTH;

    logic [COORD_WIDTH-1:0] vtx_reg [9];
    logic [ENT_W-1:0]       fifo_mem [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;
    logic                   accept;
    logic                   ray_push;
    logic                   load_vtx;
    logic                   do_pop;
    logic [ENT_W-1:0]       entry;
    logic [3:0]             vtx_base;

    assign full     = (count_reg == 2'd2);
    assign accept   = push && !full;
    assign ray_push = accept && (mode == rtc_pkg::MODE_RAY);
    assign load_vtx = accept && (mode == rtc_pkg::MODE_LOAD)
                      && (vertex_index != rtc_pkg::VERTEX_NONE);
    assign q_valid  = (count_reg != 2'd0);
    assign do_pop   = q_pop && q_valid;
    assign q_data   = fifo_mem[rd_ptr_reg];
    assign vtx_base = {1'b0, vertex_index, 1'b0} + {2'b00, vertex_index};

    // vertex store, written by load requests
    always_ff @(posedge clk)
    begin
        if (load_vtx)
        begin
            vtx_reg[vtx_base]        <= point_x;
            vtx_reg[vtx_base + 4'd1] <= point_y;
            vtx_reg[vtx_base + 4'd2] <= point_z;
        end
    end

    // ray request with a snapshot of the triangle
    always_comb
    begin
        entry = {dir_z, dir_y, dir_x, point_z, point_y, point_x};
        for (int k = 0; k < 9; k++)
        begin
            entry[(6 + k)*COORD_WIDTH +: COORD_WIDTH] = vtx_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ray_push)
        begin
            fifo_mem[wr_ptr_reg] <= entry;
        end
    end

    // queue pointers
    always_comb
    begin
        wr_ptr_next = ray_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, ray_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/rtc_back.sv @@
module rtc_back #(
    parameter int COORD_WIDTH = rtc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rtc_pkg::FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_valid,
    output logic                                        q_pop,
    input  logic [rtc_pkg::NUM_FIELDS*COORD_WIDTH-1:0]  q_data,
    input  logic [rtc_pkg::EPS_W-1:0]                   epsilon,
    output logic                                        empty,
    input  logic                                        pop,
    output logic                                        hit,
    output logic [1:0]                                  miss_reason,
    output logic signed [rtc_pkg::OUT_W-1:0]            distance
);

    localparam int ENT_W   = rtc_pkg::NUM_FIELDS * COORD_WIDTH;
    localparam int IN_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int VW      = rtc_pkg::VAL_W;
    localparam int OW      = rtc_pkg::OUT_W;
    localparam rtc_pkg::prog_t PROG = rtc_pkg::build_prog();

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_EXEC = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_MULW = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_DIVW = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    localparam logic [OW-1:0] DIST_MISS = OW'(0) - (OW'(1) << FRAC_BITS);
    localparam logic [VW-1:0] DIST_MAX  = VW'({1'b0, {(OW-1){1'b1}}});

    logic [3:0]                  state_reg, state_next;
    logic [rtc_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [ENT_W-1:0]            entry_reg;
    rtc_pkg::uop_t               uop;

    // register file
    logic [VW-1:0]               rf_mem [rtc_pkg::RF_DEPTH];
    logic [VW-1:0]               rd_a_reg, rd_b_reg;
    logic                        we;
    logic [rtc_pkg::REG_AW-1:0]  waddr;
    logic [VW-1:0]               wdata;

    // multiplier
    logic [VW-1:0]               ma_reg, ma_next, mb_reg, mb_next;
    logic                        mneg_reg, mneg_next;
    logic [2:0]                  mcnt_reg, mcnt_next;
    logic [VW-1:0]               pp_reg, pp_next;
    logic [1:0]                  psh_reg, psh_next;
    logic [2*VW-1:0]             acc_reg, acc_next;
    logic [2*VW-1:0]             pp_term;
    logic [2*VW-1:0]             prod_sh;

    // divider
    logic [2*VW-1:0]             dn_reg, dn_next;
    logic [VW-1:0]               rem_reg, rem_next, dd_reg, dd_next;
    logic                        dneg_reg, dneg_next;
    logic [6:0]                  dcnt_reg, dcnt_next;
    logic [VW-1:0]               rem_sh;
    logic [2*VW-1:0]             dn_sh;

    // result
    logic [1:0]                  res_reason_reg, res_reason_next;
    logic [OW-1:0]               res_dist_reg, res_dist_next;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  out_reason_reg, out_reason_next;
    logic [OW-1:0]               out_dist_reg, out_dist_next;

    logic [COORD_WIDTH-1:0]      fld;
    logic [VW-1:0]               ld_val;
    logic [VW-1:0]               eps64, neg_eps;

    assign uop     = PROG[pc_reg];
    assign eps64   = {{(VW - rtc_pkg::EPS_W){1'b0}}, epsilon};
    assign neg_eps = VW'(0) - eps64;
    assign q_pop   = (state_reg == S_IDLE) && q_valid;

    assign empty       = !out_valid_reg;
    assign hit         = (out_reason_reg == rtc_pkg::MISS_NONE);
    assign miss_reason = out_reason_reg;
    assign distance    = out_dist_reg;

    // field select for copy operations
    always_comb
    begin
        fld = entry_reg[COORD_WIDTH-1:0];
        for (int k = 0; k < rtc_pkg::NUM_FIELDS; k++)
        begin
            if (uop.a == rtc_pkg::REG_AW'(k))
            begin
                fld = entry_reg[k*COORD_WIDTH +: COORD_WIDTH];
            end
        end
        ld_val = {{(VW - IN_BITS){fld[IN_BITS-1]}}, fld[IN_BITS-1:0]};
    end

    // partial product placement
    always_comb
    begin
        unique case (psh_reg)
            2'd0:    pp_term = {{VW{1'b0}}, pp_reg};
            2'd1:    pp_term = {{(VW/2){1'b0}}, pp_reg, {(VW/2){1'b0}}};
            2'd2:    pp_term = {pp_reg, {VW{1'b0}}};
            default: pp_term = '0;
        endcase
        prod_sh = acc_reg >> FRAC_BITS;
    end

    // restoring divide step
    always_comb
    begin
        rem_sh = {rem_reg[VW-2:0], dn_reg[2*VW-1]};
        dn_sh  = {dn_reg[2*VW-2:0], 1'b0};
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        we              = 1'b0;
        waddr           = uop.dst;
        wdata           = '0;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        mneg_next       = mneg_reg;
        mcnt_next       = mcnt_reg;
        pp_next         = pp_reg;
        psh_next        = psh_reg;
        acc_next        = acc_reg;
        dn_next         = dn_reg;
        rem_next        = rem_reg;
        dd_next         = dd_reg;
        dneg_next       = dneg_reg;
        dcnt_next       = dcnt_reg;
        res_reason_next = res_reason_reg;
        res_dist_next   = res_dist_reg;
        out_valid_next  = (pop && out_valid_reg) ? 1'b0 : out_valid_reg;
        out_reason_next = out_reason_reg;
        out_dist_next   = out_dist_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pc_next    = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                pc_next    = pc_reg + 1'b1;
                state_next = S_READ;
                unique case (uop.op)
                    rtc_pkg::OP_LD:
                    begin
                        we    = 1'b1;
                        wdata = ld_val;
                    end
                    rtc_pkg::OP_ADD:
                    begin
                        we    = 1'b1;
                        wdata = rtc_pkg::sat_add(rd_a_reg, rd_b_reg);
                    end
                    rtc_pkg::OP_SUB:
                    begin
                        we    = 1'b1;
                        wdata = rtc_pkg::sat_sub(rd_a_reg, rd_b_reg);
                    end
                    rtc_pkg::OP_MUL:
                    begin
                        ma_next    = rtc_pkg::mag64(rd_a_reg);
                        mb_next    = rtc_pkg::mag64(rd_b_reg);
                        mneg_next  = rd_a_reg[VW-1] ^ rd_b_reg[VW-1];
                        mcnt_next  = '0;
                        acc_next   = '0;
                        pc_next    = pc_reg;
                        state_next = S_MUL;
                    end
                    rtc_pkg::OP_DIV:
                    begin
                        dn_next    = {{VW{1'b0}}, rtc_pkg::mag64(rd_a_reg)} << FRAC_BITS;
                        rem_next   = '0;
                        dd_next    = rtc_pkg::mag64(rd_b_reg);
                        dneg_next  = rd_a_reg[VW-1] ^ rd_b_reg[VW-1];
                        dcnt_next  = '0;
                        pc_next    = pc_reg;
                        state_next = S_DIV;
                    end
                    rtc_pkg::OP_CHKPAR:
                    begin
                        if (rd_a_reg == '0 || rtc_pkg::mag64(rd_a_reg) < eps64)
                        begin
                            res_reason_next = rtc_pkg::MISS_PARALLEL;
                            res_dist_next   = DIST_MISS;
                            state_next      = S_DONE;
                        end
                    end
                    rtc_pkg::OP_CHKBEH:
                    begin
                        if ($signed(rd_a_reg) < $signed(eps64))
                        begin
                            res_reason_next = rtc_pkg::MISS_BEHIND;
                            res_dist_next   = DIST_MISS;
                            state_next      = S_DONE;
                        end
                    end
                    rtc_pkg::OP_CHKOUT:
                    begin
                        if ($signed(rd_a_reg) < $signed(neg_eps))
                        begin
                            res_reason_next = rtc_pkg::MISS_OUTSIDE;
                            res_dist_next   = DIST_MISS;
                            state_next      = S_DONE;
                        end
                    end
                    rtc_pkg::OP_END:
                    begin
                        res_reason_next = rtc_pkg::MISS_NONE;
                        res_dist_next   = ($signed(rd_a_reg) > $signed(DIST_MAX))
                                          ? DIST_MAX[OW-1:0] : rd_a_reg[OW-1:0];
                        state_next      = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MUL:
            begin
                // one 32x32 partial product a cycle, each registered before it is added to the accumulator
                if (mcnt_reg < 3'd4)
                begin
                    pp_next  = VW'((mcnt_reg[1] ? ma_reg[VW-1:VW/2] : ma_reg[VW/2-1:0])
                                 * (mcnt_reg[0] ? mb_reg[VW-1:VW/2] : mb_reg[VW/2-1:0]));
                    psh_next = {1'b0, mcnt_reg[1]} + {1'b0, mcnt_reg[0]};
                end
                if (mcnt_reg != 3'd0)
                begin
                    acc_next = acc_reg + pp_term;
                end
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 3'd4)
                begin
                    state_next = S_MULW;
                end
            end
            S_MULW:
            begin
                we         = 1'b1;
                wdata      = rtc_pkg::from_mag(mneg_reg, prod_sh[2*VW-1:VW], prod_sh[VW-1:0]);
                pc_next    = pc_reg + 1'b1;
                state_next = S_READ;
            end
            S_DIV:
            begin
                dn_next  = dn_sh;
                rem_next = rem_sh;
                if (rem_reg[VW-1] || rem_sh >= dd_reg)
                begin
                    rem_next   = rem_sh - dd_reg;
                    dn_next[0] = 1'b1;
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 7'd127)
                begin
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                we         = 1'b1;
                wdata      = rtc_pkg::from_mag(dneg_reg, dn_reg[2*VW-1:VW], dn_reg[VW-1:0]);
                pc_next    = pc_reg + 1'b1;
                state_next = S_READ;
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next  = 1'b1;
                    out_reason_next = res_reason_reg;
                    out_dist_next   = res_dist_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // register file: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rf_mem[waddr] <= wdata;
        end
        rd_a_reg <= rf_mem[uop.a];
        rd_b_reg <= rf_mem[uop.b];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            entry_reg <= q_data;
        end
        ma_reg         <= ma_next;
        mb_reg         <= mb_next;
        mneg_reg       <= mneg_next;
        pp_reg         <= pp_next;
        psh_reg        <= psh_next;
        acc_reg        <= acc_next;
        dn_reg         <= dn_next;
        rem_reg        <= rem_next;
        dd_reg         <= dd_next;
        dneg_reg       <= dneg_next;
        res_reason_reg <= res_reason_next;
        res_dist_reg   <= res_dist_next;
        out_reason_reg <= out_reason_next;
        out_dist_reg   <= out_dist_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            mcnt_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            mcnt_reg      <= mcnt_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/ray_triangle_intersection_core.sv @@
// Vertex loads are stored in the front block's vertex registers and produce no result.
// A ray request runs in the sequencer as 70 simple register ops, 45 multiplies on
// one shared 32x32 multiplier, and one 128-step serial divide for t; it ends early
// when the ray misses. The sequencer takes a new ray only when idle; two rays may
// queue ahead of it.
// Reset (rst_n, async, low) empties both queues and sets epsilon to 1; vertices are kept.
module ray_triangle_intersection_core #(
    parameter int COORD_WIDTH = rtc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rtc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtc_pkg::APB_AW-1:0]        paddr,
    input  logic [rtc_pkg::APB_DW-1:0]        pwdata,
    output logic [rtc_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic                              mode,
    input  logic [1:0]                        vertex_index,
    input  logic signed [COORD_WIDTH-1:0]     point_x,
    input  logic signed [COORD_WIDTH-1:0]     point_y,
    input  logic signed [COORD_WIDTH-1:0]     point_z,
    input  logic signed [COORD_WIDTH-1:0]     dir_x,
    input  logic signed [COORD_WIDTH-1:0]     dir_y,
    input  logic signed [COORD_WIDTH-1:0]     dir_z,
    output logic                              empty,
    input  logic                              pop,
    output logic                              hit,
    output logic [1:0]                        miss_reason,
    output logic signed [rtc_pkg::OUT_W-1:0]  distance
);

    localparam int ENT_W = rtc_pkg::NUM_FIELDS * COORD_WIDTH;

    logic [rtc_pkg::EPS_W-1:0] epsilon_reg, epsilon_next;
    logic                      q_valid;
    logic                      q_pop;
    logic [ENT_W-1:0]          q_data;
    logic                      sel_eps;

    // configuration port
    assign pready  = 1'b1;
    assign sel_eps = (paddr[rtc_pkg::APB_AW-1] == rtc_pkg::REG_EPSILON);
    assign prdata  = sel_eps ? {{(rtc_pkg::APB_DW - rtc_pkg::EPS_W){1'b0}}, epsilon_reg} : '0;

    always_comb
    begin
        epsilon_next = epsilon_reg;
        if (psel && penable && pwrite && pready && sel_eps)
        begin
            epsilon_next = pwdata[rtc_pkg::EPS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= rtc_pkg::EPS_RESET;
        end
        else
        begin
            epsilon_reg <= epsilon_next;
        end
    end

    rtc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .vertex_index (vertex_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_data       (q_data)
    );

    rtc_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_data),
        .epsilon     (epsilon_reg),
        .empty       (empty),
        .pop         (pop),
        .hit         (hit),
        .miss_reason (miss_reason),
        .distance    (distance)
    );

endmodule
